// ===== hdl/dif_pkg.sv =====
package dif_pkg;

  localparam logic [7:0] DigitBase = 8'd48;
  localparam logic [7:0] MinusChar = 8'd45;
  localparam logic [7:0] EndCharRst = 8'd10;
  localparam logic [3:0] DabbleMin = 4'd5;
  localparam logic [3:0] DabbleAdd = 4'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_DIGIT,
    ST_TERM
  } dif_state_e;

  // Commands from the sequencer to the shift-add-3 unit
  typedef struct packed {
    logic load;
    logic shift;
  } dif_ctrl_t;

endpackage

// ===== hdl/dif_dabble.sv =====
module dif_dabble #(
  parameter int VALUE_BITS = 64,
  parameter int NDIG = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dif_pkg::dif_ctrl_t    ctrl_i,
  input  logic [VALUE_BITS-1:0] mag_i,
  output logic                  done_o,
  output logic [3:0]            top_digit_o
);
  import dif_pkg::*;

  localparam int CW = $clog2(VALUE_BITS);
  localparam int BW = 4 * NDIG;

  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BW-1:0]         bcd_q, bcd_d, adj;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  run_q, run_d;

  // Add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_q[4*i +: 4] >= DabbleMin) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + DabbleAdd;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  assign done_o      = run_q && (cnt_q == CW'(VALUE_BITS - 1));
  assign top_digit_o = bcd_q[BW-1 -: 4];

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    run_d = run_q;
    if (ctrl_i.load) begin
      bin_d = mag_i;
      bcd_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      bcd_d = {adj[BW-2:0], bin_q[VALUE_BITS-1]};
      bin_d = {bin_q[VALUE_BITS-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (done_o) begin
        run_d = 1'b0;
      end
    end else if (ctrl_i.shift) begin
      // Move the next digit to the top
      bcd_d = {bcd_q[BW-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      run_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

endmodule

// ===== hdl/decimal_integer_formatter.sv =====
// Order: the '-' (if any) shows in the cycle after start; digits follow once
// the shift-add-3 unit has run, one BCD digit slot at a time from the top
// (leading zeros are skipped but still take their slot), then the terminator.
// A new word is accepted only while idle (busy_o low), not during a conversion.
// Results are strobed for one cycle each; the receiver cannot stall.
// Reset: asynchronous, active low; idle, end_char back to newline.
module decimal_integer_formatter #(
  parameter int VALUE_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [63:0] value_i,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i,
  output logic        text_valid_o,
  output logic [7:0]  text_char_o,
  output logic        last_o
);
  import dif_pkg::*;

  // Enough BCD digits for 2^(VALUE_BITS-1)
  localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int DW   = $clog2(NDIG);

  dif_state_e state_q, state_d;
  dif_ctrl_t  ctrl;

  logic [7:0]            end_char_q;
  logic [DW-1:0]         dig_q, dig_d;
  logic                  seen_q, seen_d;
  logic                  valid_q, valid_d;
  logic [7:0]            char_q, char_d;
  logic                  last_q, last_d;
  logic [VALUE_BITS-1:0] v, mag;
  logic                  neg, done;
  logic [3:0]            top_digit;

  assign v   = value_i[VALUE_BITS-1:0];
  assign neg = v[VALUE_BITS-1];
  assign mag = neg ? (~v + 1'b1) : v;

  dif_dabble #(
    .VALUE_BITS(VALUE_BITS),
    .NDIG      (NDIG)
  ) u_dabble (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .mag_i      (mag),
    .done_o     (done),
    .top_digit_o(top_digit)
  );

  always_comb begin
    state_d    = state_q;
    dig_d      = dig_q;
    seen_d     = seen_q;
    valid_d    = 1'b0;
    char_d     = char_q;
    last_d     = 1'b0;
    ctrl.load  = 1'b0;
    ctrl.shift = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctrl.load = 1'b1;
          valid_d   = neg;
          char_d    = MinusChar;
          state_d   = ST_CONV;
        end
      end
      ST_CONV: begin
        if (done) begin
          dig_d   = DW'(NDIG - 1);
          seen_d  = 1'b0;
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        // Drop leading zeros, but always print the units digit
        ctrl.shift = 1'b1;
        char_d     = DigitBase + {4'd0, top_digit};
        if (top_digit != 4'd0 || seen_q || dig_q == '0) begin
          valid_d = 1'b1;
          seen_d  = 1'b1;
        end
        if (dig_q == '0) begin
          state_d = ST_TERM;
        end else begin
          dig_d = dig_q - 1'b1;
        end
      end
      ST_TERM: begin
        valid_d = 1'b1;
        char_d  = end_char_q;
        last_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      end_char_q <= EndCharRst;
      dig_q      <= '0;
      seen_q     <= 1'b0;
      valid_q    <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      dig_q   <= dig_d;
      seen_q  <= seen_d;
      valid_q <= valid_d;
      last_q  <= last_d;
      if (cfg_we_i) begin
        end_char_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign text_valid_o = valid_q;
  assign text_char_o  = char_q;
  assign last_o       = last_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy not raised after start");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> text_valid_o && !busy_o)
    else $error("terminator while busy or without strobe");

  a_char_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_valid_o && !last_o |-> busy_o)
    else $error("sign or digit word outside a conversion");

  a_conv_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CONV && done |=> state_q == ST_DIGIT)
    else $error("digit scan did not follow conversion");

endmodule
